### rtl/sedge_pkg.sv
package sedge_pkg;

	localparam int WIDTH_LIMIT  = 2048;
	localparam int HEIGHT_LIMIT = 2048;
	localparam int MIN_SIZE     = 3;

	localparam int SIZE_W  = 12;
	localparam int POS_W   = 11;
	localparam int THR_W   = 11;
	localparam int PIX_W   = 8;
	localparam int GRAD_W  = 11;
	localparam int SQ_W    = 21;
	localparam int MAG_W   = 22;
	localparam int LIM_W   = 23;
	localparam int ADDR_W  = $clog2(WIDTH_LIMIT);

	localparam int GRAY_SUM_W  = 10;
	localparam int GRAY_RECIP  = 683;
	localparam int GRAY_SHIFT  = 11;
	localparam int GRAY_PROD_W = 20;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
	localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(128);

	localparam logic [PIX_W-1:0] EDGE_VALUE = PIX_W'(0);
	localparam logic [PIX_W-1:0] FLAT_VALUE = PIX_W'(255);

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH    = 2'd0,
		REG_FRAME_HEIGHT   = 2'd1,
		REG_EDGE_THRESHOLD = 2'd2
	} sedge_reg_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic [POS_W-1:0]         column;
		logic [POS_W-1:0]         row;
		logic                     frame_done;
	} sedge_entry_t;

	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v < SIZE_W'(MIN_SIZE)) r = SIZE_W'(MIN_SIZE);
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

### rtl/sedge_front.sv
module sedge_front import sedge_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SIZE_W-1:0]   width_used,
	input  logic [SIZE_W-1:0]   height_used,
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  logic [PIX_W-1:0]    red,
	input  logic [PIX_W-1:0]    green,
	input  logic [PIX_W-1:0]    blue,
	input  logic                frame_start,
	input  logic                q_full,
	output logic                q_push,
	output sedge_entry_t        q_entry
);

	logic [POS_W-1:0] col_q, row_q;
	logic [SIZE_W-1:0] c_cur, r_cur, x_inc, y_inc;
	logic [POS_W-1:0] x_cur, y_cur, col_d, row_d;
	logic accept, s1_adv;

	logic [GRAY_SUM_W-1:0] gsum;
	logic [GRAY_PROD_W-1:0] gprod;
	logic [PIX_W-1:0] gray;

	logic valid_s1, emit_s1, done_s1, byp_s1;
	logic [POS_W-1:0] x_s1, y_s1;
	logic [PIX_W-1:0] gray_s1;
	logic [2*PIX_W-1:0] rd_s1, byp_data_s1;

	logic [2*PIX_W-1:0] line_mem [WIDTH_LIMIT];
	logic [PIX_W-1:0] win_q [6];
	logic [PIX_W-1:0] ct, cm, cb;
	logic [GRAD_W-2:0] sx_pos, sx_neg, sy_pos, sy_neg;

	always_comb begin
		c_cur = frame_start ? '0 : {1'b0, col_q};
		r_cur = frame_start ? '0 : {1'b0, row_q};
		if (c_cur >= width_used) begin
			c_cur = '0;
			r_cur = r_cur + SIZE_W'(1);
		end
		if (r_cur >= height_used) r_cur = '0;
		x_cur = c_cur[POS_W-1:0];
		y_cur = r_cur[POS_W-1:0];
		x_inc = {1'b0, x_cur} + SIZE_W'(1);
		y_inc = {1'b0, y_cur} + SIZE_W'(1);
		if (x_inc >= width_used) begin
			col_d = '0;
			row_d = (y_inc >= height_used) ? '0 : y_inc[POS_W-1:0];
		end else begin
			col_d = x_inc[POS_W-1:0];
			row_d = y_cur;
		end
	end

	assign gsum  = GRAY_SUM_W'(red) + GRAY_SUM_W'(green) + GRAY_SUM_W'(blue);
	assign gprod = GRAY_PROD_W'(gsum) * GRAY_PROD_W'(GRAY_RECIP);
	assign gray  = gprod[GRAY_SHIFT +: PIX_W];

	assign s1_adv      = valid_s1 && !q_full;
	assign pixel_stall = valid_s1 && q_full;
	assign accept      = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (accept) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1        <= x_cur;
			y_s1        <= y_cur;
			gray_s1     <= gray;
			emit_s1     <= (x_cur >= POS_W'(2)) && (y_cur >= POS_W'(2));
			done_s1     <= (x_inc == width_used) && (y_inc == height_used);
			byp_s1      <= s1_adv && (x_s1 == x_cur);
			byp_data_s1 <= {cm, gray_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) line_mem[x_s1[ADDR_W-1:0]] <= {cm, gray_s1};
		if (accept) rd_s1 <= line_mem[x_cur[ADDR_W-1:0]];
	end

	assign ct = byp_s1 ? byp_data_s1[2*PIX_W-1:PIX_W] : rd_s1[2*PIX_W-1:PIX_W];
	assign cm = byp_s1 ? byp_data_s1[PIX_W-1:0] : rd_s1[PIX_W-1:0];
	assign cb = gray_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= ct;
			win_q[4] <= cm;
			win_q[5] <= cb;
		end
	end

	always_comb begin
		sx_pos = (GRAD_W-1)'(ct) + {1'b0, cm, 1'b0} + (GRAD_W-1)'(cb);
		sx_neg = (GRAD_W-1)'(win_q[0]) + {1'b0, win_q[1], 1'b0} + (GRAD_W-1)'(win_q[2]);
		sy_pos = (GRAD_W-1)'(win_q[2]) + {1'b0, win_q[5], 1'b0} + (GRAD_W-1)'(cb);
		sy_neg = (GRAD_W-1)'(win_q[0]) + {1'b0, win_q[3], 1'b0} + (GRAD_W-1)'(ct);
		q_entry.gx         = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
		q_entry.gy         = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
		q_entry.column     = x_s1 - POS_W'(1);
		q_entry.row        = y_s1 - POS_W'(1);
		q_entry.frame_done = done_s1;
	end

	assign q_push = s1_adv && emit_s1;

endmodule

### rtl/sedge_fifo.sv
module sedge_fifo import sedge_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  sedge_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output sedge_entry_t pop_entry
);

	sedge_entry_t slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + FIFO_CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - FIFO_CNT_W'(1);
		end
	end

endmodule

### rtl/sedge_back.sv
module sedge_back import sedge_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [THR_W-1:0]  threshold,
	input  logic              q_not_empty,
	input  sedge_entry_t      q_entry,
	output logic              q_pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [PIX_W-1:0]  pixel_value,
	output logic [POS_W-1:0]  column,
	output logic [POS_W-1:0]  row,
	output logic              frame_done
);

	logic valid_s2, valid_s3, ld_s3, free_s2;
	logic [SQ_W-1:0] gx2_s2, gy2_s2;
	logic [LIM_W-1:0] lim_s2;
	logic [POS_W-1:0] col_s2, row_s2;
	logic done_s2;
	logic signed [2*GRAD_W-1:0] sqx, sqy;
	logic [SIZE_W-1:0] thr_inc;
	logic [2*SIZE_W-1:0] lim_full;
	logic [MAG_W-1:0] mag;

	assign ld_s3   = valid_s2 && (!valid_s3 || !result_stall);
	assign free_s2 = !valid_s2 || ld_s3;
	assign q_pop   = q_not_empty && free_s2;

	assign sqx      = (2*GRAD_W)'(q_entry.gx) * (2*GRAD_W)'(q_entry.gx);
	assign sqy      = (2*GRAD_W)'(q_entry.gy) * (2*GRAD_W)'(q_entry.gy);
	assign thr_inc  = {1'b0, threshold} + SIZE_W'(1);
	assign lim_full = (2*SIZE_W)'(thr_inc) * (2*SIZE_W)'(thr_inc);
	assign mag      = {1'b0, gx2_s2} + {1'b0, gy2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (q_pop) valid_s2 <= 1'b1;
			else if (ld_s3) valid_s2 <= 1'b0;
			if (ld_s3) valid_s3 <= 1'b1;
			else if (!result_stall) valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			gx2_s2  <= sqx[SQ_W-1:0];
			gy2_s2  <= sqy[SQ_W-1:0];
			lim_s2  <= lim_full[LIM_W-1:0];
			col_s2  <= q_entry.column;
			row_s2  <= q_entry.row;
			done_s2 <= q_entry.frame_done;
		end
		if (ld_s3) begin
			pixel_value <= ({1'b0, mag} >= lim_s2) ? EDGE_VALUE : FLAT_VALUE;
			column      <= col_s2;
			row         <= row_s2;
			frame_done  <= done_s2;
		end
	end

	assign result_valid = valid_s3;

endmodule

### rtl/sobel_edge_threshold_top.sv
// Sobel edge classifier for an RGB pixel stream in raster order.
// Pixel channel: pixel_valid/pixel_stall with red, green, blue and
// frame_start; frame_start places the pixel at column 0, row 0.
// Result channel: result_valid/result_stall with pixel_value (0 edge,
// 255 flat), column, row and frame_done. Only interior pixels give a
// result; border pixels give none.
// Configuration: APB-style writes to frame_width (0x0), frame_height (0x4)
// and edge_threshold (0x8), only while the block is idle.
// Throughput: one pixel per cycle while pixel_stall is low, set by the
// line store that takes one read and one write for every pixel. A result
// is registered after the window stage, queue and magnitude stages.
// A four-entry queue sits between the window stage and the magnitude
// stages; when result_stall holds the output, the queue fills and then
// pixel_stall rises until space frees up.
// Reset clears the position, the window and all valid flags and restores
// 640x480 with threshold 128; line store contents are undefined until
// the first two rows of a frame are written.
module sobel_edge_threshold_top import sedge_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [PIX_W-1:0]      red,
	input  logic [PIX_W-1:0]      green,
	input  logic [PIX_W-1:0]      blue,
	input  logic                  frame_start,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [PIX_W-1:0]      pixel_value,
	output logic [POS_W-1:0]      column,
	output logic [POS_W-1:0]      row,
	output logic                  frame_done
);

	logic [SIZE_W-1:0] width_q, height_q, width_used, height_used;
	logic [THR_W-1:0] thr_q;
	logic wr_en;
	sedge_reg_t reg_sel;

	logic q_full, q_push, q_pop, q_not_empty;
	sedge_entry_t push_entry, pop_entry;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = sedge_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thr_q    <= THR_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_FRAME_WIDTH:    width_q  <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT:   height_q <= pwdata[SIZE_W-1:0];
				REG_EDGE_THRESHOLD: thr_q    <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_FRAME_WIDTH:    prdata = APB_DATA_W'(width_q);
			REG_FRAME_HEIGHT:   prdata = APB_DATA_W'(height_q);
			REG_EDGE_THRESHOLD: prdata = APB_DATA_W'(thr_q);
			default:            prdata = '0;
		endcase
	end

	assign width_used  = sat_size(width_q, SIZE_W'(WIDTH_LIMIT));
	assign height_used = sat_size(height_q, SIZE_W'(HEIGHT_LIMIT));

	sedge_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.width_used  (width_used),
		.height_used (height_used),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_start (frame_start),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (push_entry)
	);

	sedge_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.pop_entry  (pop_entry)
	);

	sedge_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.threshold    (thr_q),
		.q_not_empty  (q_not_empty),
		.q_entry      (pop_entry),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixel_value  (pixel_value),
		.column       (column),
		.row          (row),
		.frame_done   (frame_done)
	);

`ifndef NO_ASSERTIONS
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (column != '0) && (row != '0))
		else $error("result outside frame interior");

	a_done_col: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |-> ({1'b0, column} + SIZE_W'(2)) == width_used)
		else $error("frame_done on wrong column");

	a_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |-> ({1'b0, row} + SIZE_W'(2)) == height_used)
		else $error("frame_done on wrong row");

	a_binary: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pixel_value == EDGE_VALUE) || (pixel_value == FLAT_VALUE))
		else $error("pixel_value not binary");
`endif

endmodule
